>>> design/lcmc_pkg.sv
package lcmc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 5;
    localparam int OCC_W       = 5;
    localparam int PAGE_W      = 32;
    localparam int MISS_W      = 32;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [PAGE_W-1:0] t_page;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_page wdata;
        logic  re;
        t_idx  raddr;
    } t_ram_req;

    // Maps a position in the recency list onto a slot of the circular store.
    function automatic t_idx lcmc_phys(t_idx head, t_cnt pos);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, pos};
        if (sum >= (CNT_W + 1)'(MAX_ENTRIES)) begin
            sum = sum - (CNT_W + 1)'(MAX_ENTRIES);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic t_cnt lcmc_eff_cap(logic [CAP_W-1:0] cap);
        t_cnt res;
        if (cap == '0) begin
            res = CNT_W'(1);
        end else if (int'(cap) > MAX_ENTRIES) begin
            res = CNT_W'(MAX_ENTRIES);
        end else begin
            res = CNT_W'(cap);
        end
        return res;
    endfunction

endpackage

>>> design/lcmc_in_if.sv
interface lcmc_in_if import lcmc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [PAGE_W-1:0] page;

    modport source (output valid, output page, input ready);
    modport sink   (input valid, input page, output ready);
endinterface

>>> design/lcmc_out_if.sv
interface lcmc_out_if import lcmc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              hit;
    logic [MISS_W-1:0] miss_total;
    logic [OCC_W-1:0]  occupancy;

    modport source (output valid, output hit, output miss_total, output occupancy, input ready);
    modport sink   (input valid, input hit, input miss_total, input occupancy, output ready);
endinterface

>>> design/lcmc_list_ram.sv
module lcmc_list_ram import lcmc_pkg::*; (
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_page    o_rdata
);

    t_page mem [MAX_ENTRIES];
    t_page r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/lcmc_ctrl.sv
module lcmc_ctrl import lcmc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    lcmc_in_if.sink          i_in,
    lcmc_out_if.source       o_out,
    output t_ram_req         o_req,
    input  t_page            i_rdata
);

    t_state            r_state,   n_state;
    t_page             r_page,    n_page;
    t_idx              r_head,    n_head;
    t_cnt              r_count,   n_count;
    t_cnt              r_rd_pos,  n_rd_pos;
    t_cnt              r_cmp_pos, n_cmp_pos;
    logic              r_found,   n_found;
    logic [CAP_W-1:0]  r_cap;
    logic [MISS_W-1:0] r_miss,    n_miss;
    logic              r_out_valid, n_out_valid;
    logic              r_out_hit,   n_out_hit;
    logic [MISS_W-1:0] r_out_miss,  n_out_miss;
    logic [OCC_W-1:0]  r_out_occ,   n_out_occ;

    t_cnt     cap_eff;
    t_cnt     evict_cnt;
    t_idx     miss_head;
    t_ram_req req;

    assign cap_eff   = lcmc_eff_cap(r_cap);
    // On a miss with the list at or above capacity, drop enough of the
    // least-recent pages to leave one free slot below the capacity.
    assign evict_cnt = (r_count >= cap_eff) ? (r_count - cap_eff + CNT_W'(1)) : '0;
    assign miss_head = lcmc_phys(r_head, evict_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_rd_pos    <= '0;
            r_cmp_pos   <= '0;
            r_found     <= 1'b0;
            r_cap       <= CAPACITY_RESET;
            r_miss      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_rd_pos    <= n_rd_pos;
            r_cmp_pos   <= n_cmp_pos;
            r_found     <= n_found;
            r_miss      <= n_miss;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_page    <= n_page;
        r_out_hit <= n_out_hit;
        r_out_miss <= n_out_miss;
        r_out_occ <= n_out_occ;
    end

    always_comb begin
        n_state     = r_state;
        n_page      = r_page;
        n_head      = r_head;
        n_count     = r_count;
        n_rd_pos    = r_rd_pos;
        n_cmp_pos   = r_cmp_pos;
        n_found     = r_found;
        n_miss      = r_miss;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_hit   = r_out_hit;
        n_out_miss  = r_out_miss;
        n_out_occ   = r_out_occ;
        req         = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_page  = $unsigned(i_in.page);
                    n_found = 1'b0;
                    if (r_count == '0) begin
                        n_state = ST_WRITE;
                    end else begin
                        req.re    = 1'b1;
                        req.raddr = lcmc_phys(r_head, '0);
                        n_rd_pos  = CNT_W'(1);
                        n_cmp_pos = '0;
                        n_state   = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_rd_pos < r_count) begin
                    req.re    = 1'b1;
                    req.raddr = lcmc_phys(r_head, r_rd_pos);
                    n_rd_pos  = r_rd_pos + CNT_W'(1);
                end
                // Once the page is found, every later entry moves down one
                // place as it streams past, closing the gap.
                if (r_found) begin
                    req.we    = 1'b1;
                    req.waddr = lcmc_phys(r_head, r_cmp_pos - CNT_W'(1));
                    req.wdata = i_rdata;
                end else if (i_rdata == r_page) begin
                    n_found = 1'b1;
                end
                n_cmp_pos = r_cmp_pos + CNT_W'(1);
                if (r_cmp_pos == r_count - CNT_W'(1)) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                req.we    = 1'b1;
                req.wdata = r_page;
                if (r_found) begin
                    req.waddr = lcmc_phys(r_head, r_count - CNT_W'(1));
                end else begin
                    req.waddr = lcmc_phys(miss_head, r_count - evict_cnt);
                    n_head    = miss_head;
                    n_count   = r_count - evict_cnt + CNT_W'(1);
                    if (r_miss != '1) begin
                        n_miss = r_miss + MISS_W'(1);
                    end
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_found;
                    n_out_miss  = r_miss;
                    n_out_occ   = OCC_W'(r_count);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_req            = req;
    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.hit        = r_out_hit;
    assign o_out.miss_total = r_out_miss;
    assign o_out.occupancy  = r_out_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("occupancy beyond the store depth");

    a_no_same_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req.we && req.re) |-> (req.waddr != req.raddr))
        else $error("read and write of the same slot in one cycle");

    a_miss_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_miss >= $past(r_miss)))
        else $error("miss count went backwards");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result presented outside the done state");

endmodule

>>> design/lru_cache_miss_counter_core.sv
// Channel   Direction  Handshake            Payload
// i_in      in         valid / ready        page (32-bit signed)
// o_out     out        valid / ready        hit, miss_total, occupancy
// i_cfg     in         i_cfg_we (no wait)   i_cfg_wdata: capacity
//
// The next item is accepted only after the previous result is loaded. An
// item scans the resident pages of the recency store, which reads one entry
// per cycle through its single read port while shifting later entries down
// through its write port.
// Reset clears occupancy, the miss count and the list head and sets capacity
// to 16; the page store itself is not cleared.
// A result waits in the output register while the next item is accepted; a
// finished item holds in its final state until that register is free.
module lru_cache_miss_counter_core import lcmc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    lcmc_in_if.sink          i_in,
    lcmc_out_if.source       o_out
);

    t_ram_req ram_req;
    t_page    ram_rdata;

    lcmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_req       (ram_req),
        .i_rdata     (ram_rdata)
    );

    lcmc_list_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

endmodule
